FILE: sv/coin_changer_greedy_dispense_unit_assert.svh
// Assertion helpers shared by the changer modules.
// Each macro expects signals named clock and reset in scope.
`ifndef COIN_CHANGER_GREEDY_DISPENSE_UNIT_ASSERT_SVH
`define COIN_CHANGER_GREEDY_DISPENSE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CCGD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CCGD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/ccgd_pkg.sv
package ccgd_pkg;

   localparam int NUM_DENOM   = 6;
   localparam int IDX_W       = 3;
   localparam int DENOM_W     = 8;
   localparam int REM_W       = 16;
   localparam int RECIP_W     = 22;
   localparam int RECIP_SHIFT = 24;
   localparam int QUOT_W      = 14;
   localparam int PROD_W      = REM_W + RECIP_W;
   localparam int QD_W        = QUOT_W + DENOM_W;
   localparam int PAID_W      = 10;
   localparam int CREDIT_W    = 16;
   localparam int PRICE_W     = 15;
   localparam int UNPAID_W    = 17;
   localparam int RETAIN_W    = 32;
   localparam int COUNT_W     = 16;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DENOM - 1);

   // transaction opcodes
   localparam logic [1:0] OP_INSERT   = 2'd0;
   localparam logic [1:0] OP_PURCHASE = 2'd1;
   localparam logic [1:0] OP_LOAD     = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_WR,
      ST_LOAD,
      ST_PAY_START,
      ST_PAY_MUL,
      ST_PAY_DIV,
      ST_PAY_UPD,
      ST_PAY_END,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic mul;
      logic div;
      logic upd;
   } step_ctl_type;

   function automatic logic [DENOM_W-1:0] denom_value(input logic [IDX_W-1:0] idx);
      logic [DENOM_W-1:0] v;
      case (idx)
         3'd0: v = 8'd200;
         3'd1: v = 8'd100;
         3'd2: v = 8'd50;
         3'd3: v = 8'd20;
         3'd4: v = 8'd10;
         3'd5: v = 8'd5;
         default: v = 8'd5;
      endcase
      return v;
   endfunction

   // floor(2^24 / denomination)
   function automatic logic [RECIP_W-1:0] denom_recip(input logic [IDX_W-1:0] idx);
      logic [RECIP_W-1:0] v;
      case (idx)
         3'd0: v = 22'd83886;
         3'd1: v = 22'd167772;
         3'd2: v = 22'd335544;
         3'd3: v = 22'd838860;
         3'd4: v = 22'd1677721;
         3'd5: v = 22'd3355443;
         default: v = 22'd3355443;
      endcase
      return v;
   endfunction

endpackage

FILE: sv/ccgd_ram.sv
module ccgd_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 6
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/ccgd_step.sv
`include "coin_changer_greedy_dispense_unit_assert.svh"

module ccgd_step
   import ccgd_pkg::*;
#(
   parameter int STOCK_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  step_ctl_type          ctl,
   input  logic [IDX_W-1:0]      idx,
   input  logic [REM_W-1:0]      rem,
   input  logic [STOCK_BITS-1:0] stock,
   output logic [STOCK_BITS-1:0] take,
   output logic [STOCK_BITS-1:0] stock_left,
   output logic [REM_W-1:0]      rem_next
);

   localparam int SV_W  = STOCK_BITS + DENOM_W;
   localparam int CMP_W = (STOCK_BITS > QUOT_W) ? STOCK_BITS : QUOT_W;

   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [STOCK_BITS-1:0] stock_ff, stock_in;
   logic [SV_W-1:0]       stock_val_ff, stock_val_in;
   logic [QUOT_W-1:0]     q0_ff, q0_in;
   logic [QD_W-1:0]       qd_ff, qd_in;

   logic [DENOM_W-1:0] d;
   logic [REM_W-1:0]   r0, r;
   logic               fix, fits;
   logic [QUOT_W-1:0]  q;

   assign d = denom_value(idx);

   // reciprocal estimate, stock value and quotient back-multiply
   always_comb begin
      prod_in      = prod_ff;
      stock_in     = stock_ff;
      stock_val_in = stock_val_ff;
      q0_in        = q0_ff;
      qd_in        = qd_ff;
      if (ctl.mul) begin
         prod_in      = PROD_W'(rem) * PROD_W'(denom_recip(idx));
         stock_in     = stock;
         stock_val_in = SV_W'(stock) * SV_W'(d);
      end
      if (ctl.div) begin
         q0_in = prod_ff[RECIP_SHIFT +: QUOT_W];
         qd_in = QD_W'(prod_ff[RECIP_SHIFT +: QUOT_W]) * QD_W'(d);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      stock_ff     <= stock_in;
      stock_val_ff <= stock_val_in;
      q0_ff        <= q0_in;
      qd_ff        <= qd_in;
   end

   // estimate is exact or one low
   always_comb begin
      r0   = rem - qd_ff[REM_W-1:0];
      fix  = (r0 >= REM_W'(d));
      r    = fix ? (r0 - REM_W'(d)) : r0;
      q    = q0_ff + QUOT_W'(fix);
      fits = (CMP_W'(q) <= CMP_W'(stock_ff));
      if (fits) begin
         take     = STOCK_BITS'(q);
         rem_next = r;
      end else begin
         take     = stock_ff;
         rem_next = rem - REM_W'(stock_val_ff);
      end
      stock_left = stock_ff - take;
   end

   `CCGD_ASSERT_NOW(a_rem_never_grows, ctl.upd, rem_next <= rem, "remainder grew")
   `CCGD_ASSERT_NOW(a_rem_below_coin, ctl.upd && fits, r < REM_W'(d), "quotient fix failed")

endmodule

FILE: sv/coin_changer_greedy_dispense_unit.sv
// Channel | Direction | Handshake             | Contents
// req     | in        | req_valid / req_ready | op, coin code, price, stock value
// rsp     | out       | rsp_valid / rsp_ready | coins paid, unpaid change, totals
//
// States before rsp_valid: insert/load: write, done; purchase owing change: start, per
// denomination mul/div/update, closing, done; owing nothing: start, closing, done; bad coin/op: done.
// req_ready returns in the same cycle that the result lands in the output register.
// Each denomination: stock read, reciprocal multiply, back-multiply, fix/write-back.
// Reset is synchronous; stock RAM is not cleared, per-entry valid bits read unwritten
// counts as zero. A stalled rsp holds the next transaction in its final state.
`include "coin_changer_greedy_dispense_unit_assert.svh"

module coin_changer_greedy_dispense_unit
   import ccgd_pkg::*;
#(
   parameter int STOCK_BITS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_op,
   input  logic [2:0]                 req_coin_code,
   input  logic [7:0]                 req_price_euros,
   input  logic [6:0]                 req_price_cents,
   input  logic [9:0]                 req_stock_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [PAID_W-1:0]          rsp_paid_200,
   output logic [PAID_W-1:0]          rsp_paid_100,
   output logic [PAID_W-1:0]          rsp_paid_50,
   output logic [PAID_W-1:0]          rsp_paid_20,
   output logic [PAID_W-1:0]          rsp_paid_10,
   output logic [PAID_W-1:0]          rsp_paid_5,
   output logic signed [UNPAID_W-1:0] rsp_unpaid_change,
   output logic [RETAIN_W-1:0]        rsp_retained_sum,
   output logic [COUNT_W-1:0]         rsp_short_transactions,
   output logic [COUNT_W-1:0]         rsp_all_transactions
);

   localparam int WIDE_W = (STOCK_BITS > PAID_W) ? STOCK_BITS : PAID_W;

   // control
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [NUM_DENOM-1:0] valid_ff, valid_in;
   logic      rd_valid_ff;

   // captured transaction
   logic [2:0]   code_ff, code_in;
   logic [7:0]   euros_ff, euros_in;
   logic [6:0]   cents_ff, cents_in;
   logic [9:0]   sval_ff, sval_in;

   // purchase datapath
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic signed [UNPAID_W-1:0] unpaid_ff, unpaid_in;
   logic [PAID_W-1:0]          paid_ff [NUM_DENOM];
   logic [PAID_W-1:0]          paid_in [NUM_DENOM];

   // running totals
   logic [CREDIT_W-1:0] credit_ff, credit_in;
   logic [RETAIN_W-1:0] retained_ff, retained_in;
   logic [COUNT_W-1:0]  short_ff, short_in;
   logic [COUNT_W-1:0]  purchase_ff, purchase_in;

   // output register
   logic [PAID_W-1:0]          rsp_paid_ff [NUM_DENOM];
   logic signed [UNPAID_W-1:0] rsp_unpaid_ff;
   logic [RETAIN_W-1:0]        rsp_retained_ff;
   logic [COUNT_W-1:0]         rsp_short_ff;
   logic [COUNT_W-1:0]         rsp_all_ff;
   logic                       rsp_load;

   // stock RAM port signals
   logic                  ram_we, ram_re;
   logic [IDX_W-1:0]      ram_waddr, ram_raddr;
   logic [STOCK_BITS-1:0] ram_wdata, ram_rdata, rd_stock;

   step_ctl_type          step_ctl;
   logic [STOCK_BITS-1:0] step_take, step_stock_left;
   logic [REM_W-1:0]      step_rem_next;

   // scratch
   logic [PRICE_W-1:0]    price_w;
   logic [UNPAID_W-1:0]   change_w;
   logic [CREDIT_W:0]     credit_sum;
   logic [RETAIN_W:0]     retain_sum;
   logic [WIDE_W-1:0]     take_wide, sval_wide;

   ccgd_ram #(
      .WIDTH (STOCK_BITS),
      .DEPTH (NUM_DENOM)
   ) u_stock_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ccgd_step #(
      .STOCK_BITS (STOCK_BITS)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .ctl        (step_ctl),
      .idx        (idx_ff),
      .rem        (rem_ff),
      .stock      (rd_stock),
      .take       (step_take),
      .stock_left (step_stock_left),
      .rem_next   (step_rem_next)
   );

   // entry never written reads as an empty tube
   assign rd_stock  = rd_valid_ff ? ram_rdata : '0;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff;
      code_in     = code_ff;
      euros_in    = euros_ff;
      cents_in    = cents_ff;
      sval_in     = sval_ff;
      idx_in      = idx_ff;
      rem_in      = rem_ff;
      unpaid_in   = unpaid_ff;
      paid_in     = paid_ff;
      credit_in   = credit_ff;
      retained_in = retained_ff;
      short_in    = short_ff;
      purchase_in = purchase_ff;
      rsp_load    = 1'b0;
      ram_we      = 1'b0;
      ram_waddr   = idx_ff;
      ram_wdata   = '0;
      ram_re      = 1'b0;
      ram_raddr   = '0;
      step_ctl    = '0;

      price_w    = PRICE_W'(euros_ff) * PRICE_W'(100) + PRICE_W'(cents_ff);
      change_w   = UNPAID_W'(credit_ff) - UNPAID_W'(price_w);
      credit_sum = (CREDIT_W + 1)'(credit_ff) + (CREDIT_W + 1)'(denom_value(code_ff));
      retain_sum = (RETAIN_W + 1)'(retained_ff)
                 + (RETAIN_W + 1)'(unpaid_ff[REM_W-1:0]);
      take_wide  = WIDE_W'(step_take);
      sval_wide  = WIDE_W'(sval_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               code_in   = req_coin_code;
               euros_in  = req_price_euros;
               cents_in  = req_price_cents;
               sval_in   = req_stock_value;
               unpaid_in = '0;
               for (int i = 0; i < NUM_DENOM; i++) begin
                  paid_in[i] = '0;
               end
               case (req_op)
                  OP_INSERT: begin
                     if (req_coin_code < IDX_W'(NUM_DENOM)) begin
                        ram_re    = 1'b1;
                        ram_raddr = req_coin_code;
                        state_in  = ST_INS_WR;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  OP_PURCHASE: state_in = ST_PAY_START;
                  OP_LOAD: begin
                     state_in = (req_coin_code < IDX_W'(NUM_DENOM)) ? ST_LOAD : ST_DONE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_INS_WR: begin
            // read-modify-write of one tube, saturating
            ram_we          = 1'b1;
            ram_waddr       = code_ff;
            ram_wdata       = (rd_stock == '1) ? rd_stock : rd_stock + 1'b1;
            valid_in[code_ff] = 1'b1;
            credit_in       = credit_sum[CREDIT_W] ? '1 : credit_sum[CREDIT_W-1:0];
            state_in        = ST_DONE;
         end
         ST_LOAD: begin
            ram_we            = 1'b1;
            ram_waddr         = code_ff;
            ram_wdata         = sval_wide[STOCK_BITS-1:0];
            valid_in[code_ff] = 1'b1;
            state_in          = ST_DONE;
         end
         ST_PAY_START: begin
            if (!change_w[UNPAID_W-1] && (change_w != '0)) begin
               rem_in    = change_w[REM_W-1:0];
               idx_in    = '0;
               ram_re    = 1'b1;
               ram_raddr = '0;
               state_in  = ST_PAY_MUL;
            end else begin
               unpaid_in = $signed(change_w);
               state_in  = ST_PAY_END;
            end
         end
         ST_PAY_MUL: begin
            step_ctl.mul = 1'b1;
            state_in     = ST_PAY_DIV;
         end
         ST_PAY_DIV: begin
            step_ctl.div = 1'b1;
            state_in     = ST_PAY_UPD;
         end
         ST_PAY_UPD: begin
            step_ctl.upd     = 1'b1;
            ram_we           = 1'b1;
            ram_waddr        = idx_ff;
            ram_wdata        = step_stock_left;
            valid_in[idx_ff] = 1'b1;
            paid_in[idx_ff]  = take_wide[PAID_W-1:0];
            rem_in           = step_rem_next;
            if (idx_ff == LAST_IDX) begin
               unpaid_in = $signed(UNPAID_W'(step_rem_next));
               state_in  = ST_PAY_END;
            end else begin
               // prefetch next tube while this one is written back
               idx_in    = idx_ff + 1'b1;
               ram_re    = 1'b1;
               ram_raddr = idx_ff + 1'b1;
               state_in  = ST_PAY_MUL;
            end
         end
         ST_PAY_END: begin
            if (unpaid_ff > 0) begin
               retained_in = retain_sum[RETAIN_W] ? '1 : retain_sum[RETAIN_W-1:0];
               short_in    = (short_ff == '1) ? short_ff : short_ff + 1'b1;
            end
            purchase_in = (purchase_ff == '1) ? purchase_ff : purchase_ff + 1'b1;
            credit_in   = '0;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         credit_ff    <= '0;
         retained_ff  <= '0;
         short_ff     <= '0;
         purchase_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         credit_ff    <= credit_in;
         retained_ff  <= retained_in;
         short_ff     <= short_in;
         purchase_ff  <= purchase_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff   <= code_in;
      euros_ff  <= euros_in;
      cents_ff  <= cents_in;
      sval_ff   <= sval_in;
      idx_ff    <= idx_in;
      rem_ff    <= rem_in;
      unpaid_ff <= unpaid_in;
      paid_ff   <= paid_in;
      if (ram_re) begin
         rd_valid_ff <= valid_ff[ram_raddr];
      end
      if (rsp_load) begin
         rsp_paid_ff     <= paid_ff;
         rsp_unpaid_ff   <= unpaid_ff;
         rsp_retained_ff <= retained_ff;
         rsp_short_ff    <= short_ff;
         rsp_all_ff      <= purchase_ff;
      end
   end

   assign rsp_paid_200           = rsp_paid_ff[0];
   assign rsp_paid_100           = rsp_paid_ff[1];
   assign rsp_paid_50            = rsp_paid_ff[2];
   assign rsp_paid_20            = rsp_paid_ff[3];
   assign rsp_paid_10            = rsp_paid_ff[4];
   assign rsp_paid_5             = rsp_paid_ff[5];
   assign rsp_unpaid_change      = rsp_unpaid_ff;
   assign rsp_retained_sum       = rsp_retained_ff;
   assign rsp_short_transactions = rsp_short_ff;
   assign rsp_all_transactions   = rsp_all_ff;

   `CCGD_ASSERT_NOW(a_no_write_idle, state_ff == ST_IDLE, !ram_we, "stock write while idle")
   `CCGD_ASSERT_NOW(a_idx_range, state_ff == ST_PAY_UPD, idx_ff <= LAST_IDX, "coin index out of range")
   `CCGD_ASSERT_NEXT(a_credit_clear, state_ff == ST_PAY_END, credit_ff == '0, "credit kept after purchase")
   `CCGD_ASSERT_NEXT(a_unpaid_nonneg, state_ff == ST_PAY_UPD && idx_ff == LAST_IDX, unpaid_ff >= 0, "negative remainder")

endmodule
